FILE: rtl/tsf_pkg.sv
// shared types and constants for the triangle span fill block
// no dependencies
package tsf_pkg;
  localparam int ROW_W = 6;
  localparam int COL_W = 8;
  localparam int SYM_W = 8;
  localparam int ROWS  = 64;
  localparam int ERR_W = 11;

  typedef struct packed {
    logic [COL_W-1:0] x0;
    logic [ROW_W-1:0] y0;
    logic [COL_W-1:0] x1;
    logic [ROW_W-1:0] y1;
    logic [COL_W-1:0] x2;
    logic [ROW_W-1:0] y2;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
    logic [SYM_W-1:0] sym;
  } tri_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_CLEAR, BK_SETUP, BK_WALK, BK_EMIT
  } bk_state_t;
endpackage

FILE: rtl/triangle_span_fill.sv
// top level of the triangle span fill block
// depends on tsf_pkg, tsf_front, tsf_back
//
// channel | dir | fields (tdata from bit 0)
// in_     | in  | a_x, a_y, b_x, b_y, c_x, c_y, fill_symbol (50 bits, 56 wide)
// out_    | out | tdata: row, first, final, symbol (30 bits, 32 wide); tlast
//
// sequence: take a triangle, then per edge a setup step and, per edge point, a row
// store read, then a merge (up to 256 points), then one span per row (up to 64),
// paced by the single edge walker
// reset: synchronous, active low, clears queue and walker state
// stalls: a two entry queue lets triangles be taken while spans drain
module triangle_span_fill (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y, fill_symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // span_row, span_first, span_final, span_symbol
  output logic        out_tlast
);
  import tsf_pkg::*;

  logic q_valid, q_ready;
  tri_t q_data;
  logic [5:0] o_row;
  logic [7:0] o_first, o_final, o_sym;

  tsf_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .ax(in_tdata[7:0]), .ay(in_tdata[13:8]), .bx(in_tdata[21:14]),
    .by(in_tdata[27:22]), .cx(in_tdata[35:28]), .cy(in_tdata[41:36]),
    .sym(in_tdata[49:42]), .q_valid, .q_ready, .q_data
  );

  tsf_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .o_row, .o_first, .o_final, .o_sym, .o_last(out_tlast)
  );

  assign out_tdata = {2'b00, o_sym, o_final, o_first, o_row};
endmodule

FILE: rtl/tsf_front.sv
// front part: accepts a triangle, orders vertices by column, finds top/bottom
// depends on tsf_pkg
module tsf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ax, bx, cx,
  input  logic [5:0]         ay, by, cy,
  input  logic [7:0]         sym,
  output logic               q_valid,
  input  logic               q_ready,
  output tsf_pkg::tri_t      q_data
);
  import tsf_pkg::*;

  // two entry queue
  tri_t q_mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  tri_t t;
  logic [7:0] x0, x1, x2, tx;
  logic [5:0] y0, y1, y2, ty, tp, bt;
  logic push, pop;

  always_comb begin
    tx = '0; ty = '0;
    x0 = ax; y0 = ay; x1 = bx; y1 = by; x2 = cx; y2 = cy;
    if (x2 < x0 || x1 < x0) begin
      if (x2 < x1) begin
        tx = x0; x0 = x2; x2 = tx; ty = y0; y0 = y2; y2 = ty;
      end else begin
        tx = x0; x0 = x1; x1 = tx; ty = y0; y0 = y1; y1 = ty;
      end
    end
    if (x2 < x1) begin
      tx = x1; x1 = x2; x2 = tx; ty = y1; y1 = y2; y2 = ty;
    end
    tp = (y0 < y1) ? y0 : y1;
    tp = (tp < y2) ? tp : y2;
    bt = (y0 > y1) ? y0 : y1;
    bt = (bt > y2) ? bt : y2;
    t = '{x0: x0, y0: y0, x1: x1, y1: y1, x2: x2, y2: y2, top: tp, bottom: bt,
          sym: sym};
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= t;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/tsf_back.sv
// back part: marks all rows unseen, walks each edge of the triangle, emits spans
// depends on tsf_pkg
module tsf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  tsf_pkg::tri_t q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    o_row,
  output logic [7:0]    o_first,
  output logic [7:0]    o_final,
  output logic [7:0]    o_sym,
  output logic          o_last
);
  import tsf_pkg::*;

  bk_state_t st_r, st_nxt;
  tri_t tri_r;
  logic [7:0] lft_r [ROWS];
  logic [7:0] rgt_r [ROWS];
  logic [7:0] lrd_r, rrd_r;
  logic [ROWS-1:0] seen_r;
  logic [1:0] edge_r, edge_nxt;
  logic [7:0] xa_r, xb_r, xa_nxt, xb_nxt;
  logic [5:0] ya_r, yb_r, ya_nxt, yb_nxt, row_r, row_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt, dx_r, dy_r, dx_nxt, dy_nxt, e2;
  logic sx_r, sy_r, sx_nxt, sy_nxt;
  logic ph_r, ph_nxt;
  logic ov_r, ov_nxt;
  logic [5:0] idx, eidx;
  logic mrg;

  assign idx  = ya_r - tri_r.top;
  assign eidx = row_r - tri_r.top;
  assign e2   = err_r <<< 1;
  assign q_ready = (st_r == BK_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    st_nxt = st_r; edge_nxt = edge_r;
    xa_nxt = xa_r; ya_nxt = ya_r; xb_nxt = xb_r; yb_nxt = yb_r;
    dx_nxt = dx_r; dy_nxt = dy_r; sx_nxt = sx_r; sy_nxt = sy_r;
    err_nxt = err_r; row_nxt = row_r; ov_nxt = ov_r; mrg = 1'b0;
    ph_nxt = ph_r;
    unique case (st_r)
      BK_IDLE: begin
        edge_nxt = 2'd0;
        if (q_valid) st_nxt = BK_SETUP;
      end
      BK_CLEAR: st_nxt = BK_SETUP;
      BK_SETUP: begin
        unique case (edge_r)
          2'd0: begin
            xa_nxt = tri_r.x0; ya_nxt = tri_r.y0; xb_nxt = tri_r.x1; yb_nxt = tri_r.y1;
          end
          2'd1: begin
            xa_nxt = tri_r.x1; ya_nxt = tri_r.y1; xb_nxt = tri_r.x2; yb_nxt = tri_r.y2;
          end
          default: begin
            xa_nxt = tri_r.x0; ya_nxt = tri_r.y0; xb_nxt = tri_r.x2; yb_nxt = tri_r.y2;
          end
        endcase
        dx_nxt = (xb_nxt > xa_nxt) ? ERR_W'(xb_nxt - xa_nxt) : ERR_W'(xa_nxt - xb_nxt);
        dy_nxt = -((yb_nxt > ya_nxt) ? ERR_W'(yb_nxt - ya_nxt) : ERR_W'(ya_nxt - yb_nxt));
        sx_nxt = xa_nxt < xb_nxt;
        sy_nxt = ya_nxt < yb_nxt;
        err_nxt = dx_nxt + dy_nxt;
        ph_nxt = 1'b0;
        st_nxt = BK_WALK;
      end
      BK_WALK: begin
        // first phase reads the row store, second merges and steps
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          mrg = 1'b1;
          if (xa_r == xb_r && ya_r == yb_r) begin
            if (edge_r == 2'd2) begin
              row_nxt = tri_r.top; st_nxt = BK_EMIT;
            end else begin
              edge_nxt = edge_r + 2'd1; st_nxt = BK_SETUP;
            end
          end else begin
            err_nxt = err_r;
            if (e2 >= dy_r) begin
              err_nxt = err_nxt + dy_r; xa_nxt = sx_r ? xa_r + 8'd1 : xa_r - 8'd1;
            end
            if (e2 <= dx_r) begin
              err_nxt = err_nxt + dx_r; ya_nxt = sy_r ? ya_r + 6'd1 : ya_r - 6'd1;
            end
          end
        end
      end
      BK_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          if (row_r == tri_r.bottom) st_nxt = BK_IDLE;
          else row_nxt = row_r + 6'd1;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
    if (ov_r && out_ready && !(st_r == BK_EMIT)) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    xa_r <= xa_nxt; ya_r <= ya_nxt; xb_r <= xb_nxt; yb_r <= yb_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    err_r <= err_nxt; row_r <= row_nxt; edge_r <= edge_nxt; ph_r <= ph_nxt;
    if (st_r == BK_IDLE && q_valid) tri_r <= q_data;
    if (st_r == BK_WALK && !ph_r) begin
      lrd_r <= lft_r[idx]; rrd_r <= rgt_r[idx];
    end
    if (mrg) begin
      if (!seen_r[idx] || xa_r < lrd_r) lft_r[idx] <= xa_r;
      if (!seen_r[idx] || xa_r > rrd_r) rgt_r[idx] <= xa_r;
    end
    if (st_r == BK_EMIT && (!ov_r || out_ready)) begin
      o_row <= row_r; o_first <= lft_r[eidx]; o_final <= rgt_r[eidx];
      o_sym <= tri_r.sym;
      o_last <= (row_r == tri_r.bottom);
    end
    if (!rst_n) begin
      st_r <= BK_IDLE; ov_r <= 1'b0; seen_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
      if (st_r == BK_IDLE) seen_r <= '0;
      else if (mrg) seen_r[idx] <= 1'b1;
    end
  end
endmodule

FILE: rtl/tsf_checker.sv
// port checker for triangle_span_fill, bound to the top level
// depends on nothing
module tsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("span changed while stalled");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast
      |=> out_tvalid && out_tdata[5:0] == $past(out_tdata[5:0]) + 6'd1)
    else $error("span order");
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[13:6] <= out_tdata[21:14])
    else $error("span first beyond final");
endmodule

bind triangle_span_fill tsf_checker u_chk (.*);
